@@ rtl/rld_pkg.sv @@
package rld_pkg;

  // Header fields
  localparam logic [7:0] CountMask   = 8'h7f;
  localparam logic [7:0] LiteralFlag = 8'h80;

  // Longest run output in words; words past this are dropped
  localparam int unsigned MaxWords = 16;

  // Command queue between front and back
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_RUN     = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_LIT = 2'd0,
    CMD_RUN = 2'd1,
    CMD_END = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  value;
    logic [6:0]  count;
  } cmd_t;

endpackage

@@ rtl/rld_front.sv @@
module rld_front import rld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  mode_e      mode_q, mode_d;
  logic [6:0] left_q, left_d;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classify each byte and track header state
  always_comb begin
    mode_d        = mode_q;
    left_d        = left_q;
    q_push_o      = 1'b0;
    q_cmd_o.kind  = CMD_LIT;
    q_cmd_o.value = in_byte_i;
    q_cmd_o.count = left_q;
    if (accept) begin
      if (mode_q == MODE_LITERAL && left_q != 7'd0) begin
        q_push_o     = 1'b1;
        q_cmd_o.kind = CMD_LIT;
        left_d       = left_q - 7'd1;
        if (left_q == 7'd1) begin
          mode_d = MODE_HEADER;
        end
      end else if (mode_q == MODE_RUN && left_q != 7'd0) begin
        q_push_o     = 1'b1;
        q_cmd_o.kind = CMD_RUN;
        left_d       = 7'd0;
        mode_d       = MODE_HEADER;
      end else if (in_byte_i == 8'h00) begin
        q_push_o     = 1'b1;
        q_cmd_o.kind = CMD_END;
        left_d       = 7'd0;
        mode_d       = MODE_HEADER;
      end else if ((in_byte_i & CountMask) == 8'h00) begin
        // empty literal: nothing owed
        left_d = 7'd0;
        mode_d = MODE_HEADER;
      end else begin
        left_d = in_byte_i[6:0];
        mode_d = ((in_byte_i & LiteralFlag) != 8'h00) ? MODE_LITERAL : MODE_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HEADER;
      left_q <= 7'd0;
    end else begin
      mode_q <= mode_d;
      left_q <= left_d;
    end
  end

endmodule

@@ rtl/rld_cmd_queue.sv @@
module rld_cmd_queue import rld_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full command queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty command queue");
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth)) else $error("command queue count out of range");

endmodule

@@ rtl/rld_back.sv @@
module rld_back import rld_pkg::*; #(
  parameter int unsigned LANE_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_data_o,
  output logic [3:0]  byte_count_o,
  output logic        run_last_o,
  output logic        stream_end_o
);

  // Lane width outside 1..8 falls back to a full 8-byte word
  localparam logic [3:0] LaneW   = (LANE_BYTES < 1 || LANE_BYTES > 8) ? 4'd8 : 4'(LANE_BYTES);
  localparam logic [3:0] LastIdx = 4'(MaxWords - 1);

  logic        started_q;
  logic [6:0]  remain_q;
  logic [3:0]  idx_q;
  logic        out_valid_q;
  logic [63:0] data_q;
  logic [3:0]  cnt_q;
  logic        last_q, end_q;

  logic        advance, done;
  logic [6:0]  rem, rem_next;
  logic [3:0]  idx, take;
  logic [63:0] data_d;
  logic [3:0]  cnt_d;
  logic        last_d, end_d;

  assign rem     = started_q ? remain_q : head_i.count;
  assign idx     = started_q ? idx_q : 4'd0;
  assign advance = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = advance && done;

  // Build the next word from the queue head
  always_comb begin
    take     = (rem < {3'b000, LaneW}) ? rem[3:0] : LaneW;
    rem_next = rem - {3'b000, take};
    data_d   = '0;
    cnt_d    = 4'd0;
    last_d   = 1'b1;
    end_d    = 1'b0;
    done     = 1'b1;
    unique case (head_i.kind)
      CMD_LIT: begin
        data_d = {56'd0, head_i.value};
        cnt_d  = 4'd1;
      end
      CMD_RUN: begin
        for (int i = 0; i < 8; i++) begin
          data_d[8*i +: 8] = (4'(i) < take) ? head_i.value : 8'h00;
        end
        cnt_d  = take;
        last_d = (rem_next == 7'd0) || (idx == LastIdx);
        done   = last_d;
      end
      CMD_END: begin
        end_d = 1'b1;
      end
      default: begin
        end_d = 1'b0;
      end
    endcase
  end

  // Load output register, track progress through a run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      remain_q    <= 7'd0;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      started_q   <= !done;
      remain_q    <= rem_next;
      idx_q       <= idx + 4'd1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      data_q <= data_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
      end_q  <= end_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = data_q;
  assign byte_count_o = cnt_q;
  assign run_last_o   = last_q;
  assign stream_end_o = end_q;

  a_end_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> byte_count_o == 4'd0 && run_last_o)
    else $error("end marker carries data or lacks last flag");
  a_lane_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o <= LaneW)
    else $error("word byte count exceeds lane width");
  a_run_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> !empty_i && head_i.kind == CMD_RUN)
    else $error("run in progress without run command at queue head");

endmodule

@@ rtl/rle_literal_run_decoder_top.sv @@
// Literal/run run-length decoder. One compressed byte is accepted per
// cycle while the two-entry command queue has room; headers are absorbed
// by the front end, literals and the zero-header end marker give one beat
// each, and a run byte gives ceil(count / LANE_BYTES) output beats (at most
// 16), one per cycle from the back end's word builder while the output is
// not stalled. A run therefore holds the back end for up to 16 beats, and
// the input stalls once the queue fills behind it. The first beat for an
// accepted byte is written into the command queue, then into the output
// register. LANE_BYTES may be set from 1 to 8; any other value acts as 8.
module rle_literal_run_decoder_top import rld_pkg::*; #(
  parameter int unsigned LANE_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_data_o,
  output logic [3:0]  byte_count_o,
  output logic        run_last_o,
  output logic        stream_end_o
);

  cmd_t push_cmd, head_cmd;
  logic push, pop, full, empty;

  rld_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  rld_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (empty)
  );

  rld_back #(
    .LANE_BYTES (LANE_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_cmd),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .byte_count_o (byte_count_o),
    .run_last_o   (run_last_o),
    .stream_end_o (stream_end_o)
  );

endmodule

@@ sim/rle_literal_run_decoder_top_tb.sv @@
`timescale 1ns / 100ps

module rle_literal_run_decoder_top_tb;
  import rld_pkg::*;

  localparam int unsigned LaneBytes   = 8;
  localparam int unsigned LaneWidth   = (LaneBytes < 1 || LaneBytes > 8) ? 8 : LaneBytes;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned StreamItems = 250;
  localparam int unsigned IdlePercent = 21;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        ends;
  } word_beat_t;

  // Track decoder state and hold the words each accepted byte should produce
  class rle_word_board;
    mode_e       mode = MODE_HEADER;
    logic [6:0]  owed = '0;
    word_beat_t  pending_words[$];
    int unsigned fail_count = 0;

    function void expand_byte(logic [7:0] b);
      word_beat_t  w;
      int unsigned left;
      int unsigned take;
      if (mode == MODE_LITERAL && owed != 0) begin
        // literal byte: pass straight through as a one-byte word
        w = '{data: 64'(b), count: 4'd1, last: 1'b1, ends: 1'b0};
        pending_words.push_back(w);
        owed--;
        if (owed == 0) mode = MODE_HEADER;
      end else if (mode == MODE_RUN && owed != 0) begin
        // run value: pack into lane-wide words, drop anything past the cap
        left = owed;
        for (int n = 0; n < MaxWords && left != 0; n++) begin
          take = (left < LaneWidth) ? left : LaneWidth;
          w.data = '0;
          for (int i = 0; i < take; i++) w.data[8*i +: 8] = b;
          left -= take;
          w.count = 4'(take);
          w.last  = (left == 0) || (n == MaxWords - 1);
          w.ends  = 1'b0;
          pending_words.push_back(w);
        end
        owed = '0;
        mode = MODE_HEADER;
      end else if (b == 8'h00) begin
        // zero header closes the stream with an empty marker
        w = '{data: '0, count: '0, last: 1'b1, ends: 1'b1};
        pending_words.push_back(w);
        owed = '0;
        mode = MODE_HEADER;
      end else if ((b & CountMask) == 0) begin
        // empty literal header: nothing owed
        owed = '0;
        mode = MODE_HEADER;
      end else begin
        owed = b[6:0];
        mode = (b & LiteralFlag) ? MODE_LITERAL : MODE_RUN;
      end
    endfunction

    function void match_word(logic [63:0] data, logic [3:0] count, logic last,
                             logic ends);
      word_beat_t w;
      if (pending_words.size() == 0) begin
        $error("unexpected beat: out_data %h byte_count %0d", data, count);
        fail_count++;
        return;
      end
      w = pending_words.pop_front();
      if (data !== w.data) begin
        $error("out_data: expected %h, actual %h", w.data, data);
        fail_count++;
      end
      if (count !== w.count) begin
        $error("byte_count: expected %0d, actual %0d", w.count, count);
        fail_count++;
      end
      if (last !== w.last) begin
        $error("run_last: expected %0d, actual %0d", w.last, last);
        fail_count++;
      end
      if (ends !== w.ends) begin
        $error("stream_end: expected %0d, actual %0d", w.ends, ends);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [63:0] out_data_o;
  logic [3:0]  byte_count_o;
  logic        run_last_o;
  logic        stream_end_o;

  rle_word_board board = new;
  bit            calm = 1'b0;
  int unsigned   item_count = 0;
  int unsigned   cycle_count = 0;

  rle_literal_run_decoder_top #(
    .LANE_BYTES(LaneBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .byte_count_o (byte_count_o),
    .run_last_o   (run_last_o),
    .stream_end_o (stream_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stall the output side at random, except in the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IdlePercent);
  end

  // Check every accepted output beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.match_word(out_data_o, byte_count_o, run_last_o, stream_end_o);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("rle_literal_run_decoder_top verification failed");
      $finish;
    end
  end

  // Offer one byte, idling at random first, and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.expand_byte(b);
    if (b != LiteralFlag) item_count++;
  endtask

  // One well-formed packet: header plus its literal bytes or run value
  task automatic send_packet(input bit literal, input logic [6:0] len);
    if (literal) begin
      send_byte(LiteralFlag | {1'b0, len});
      repeat (len) send_byte(8'($urandom));
    end else begin
      send_byte({1'b0, len});
      send_byte(8'($urandom));
    end
  endtask

  initial begin
    int unsigned pick;
    logic [6:0]  len;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: end marker, empty literal, literal extremes, run sizes
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h81); send_byte(8'h00);
    send_byte(8'h82); send_byte(8'hff); send_byte(8'h5a);
    send_byte(8'h01); send_byte(8'ha5);
    send_byte(8'h08); send_byte(8'h3c);
    send_byte(8'h09); send_byte(8'hc3);
    send_byte(8'h7f); send_byte(8'hff);
    send_byte(8'h11); send_byte(8'h01);
    send_byte(8'h00);

    // Random packets, with a stretch free of idling on both sides
    while (item_count < StreamItems) begin
      calm = (item_count >= 100 && item_count < 150);
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 1))
                                      : 7'($urandom_range(16, 1));
      if (pick < 8) send_byte(8'h00);
      else if (pick < 12) send_byte(LiteralFlag);
      else if (pick < 16) send_byte(8'($urandom));
      else send_packet(pick < 55, len);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // Drain outstanding words, then let the pipeline settle
    while (board.pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (board.fail_count == 0) begin
      $display("rle_literal_run_decoder_top verification clean");
    end else begin
      $display("rle_literal_run_decoder_top verification failed");
    end
    $finish;
  end

endmodule
